[src/counting_semaphore_table_assert.svh]
// Assertion macros used by the semaphore table top level.
`ifndef COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[src/cst_pkg.sv]
// Package with sizes, codes and the sequencer state type of the semaphore table.
`timescale 1ns / 1ps
package cst_pkg;
  localparam int SemCount     = 16;
  localparam int SleeperCount = 16;
  localparam int SemIdxW      = $clog2(SemCount);
  localparam int SlpIdxW      = $clog2(SleeperCount);
  localparam int SemCntW      = $clog2(SemCount + 1);
  localparam int SlpCntW      = $clog2(SleeperCount + 1);

  localparam logic [1:0] CmdGet     = 2'd0;
  localparam logic [1:0] CmdClose   = 2'd1;
  localparam logic [1:0] CmdOperate = 2'd2;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StNotSup = 3'd1;
  localparam logic [2:0] StInval  = 3'd2;
  localparam logic [2:0] StExist  = 3'd3;
  localparam logic [2:0] StNoEnt  = 3'd4;
  localparam logic [2:0] StNoSpc  = 3'd5;

  localparam logic [1:0] ActDone  = 2'd0;
  localparam logic [1:0] ActBlock = 2'd1;
  localparam logic [1:0] ActWake  = 2'd2;

  localparam logic [15:0] Max16 = 16'hFFFF;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_GETSC = 6'b000010,
    S_ENTRD = 6'b000100,
    S_SLPSC = 6'b001000,
    S_SLPIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Compare request to the shared compare unit.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic eq;
    logic le;
  } cmp_rsp_t;
endpackage

[src/cst_ram.sv]
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
module cst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/cst_cmp.sv]
// Shared compare unit used by every scan step.
`timescale 1ns / 1ps
module cst_cmp (
  input  cst_pkg::cmp_req_t req,
  output cst_pkg::cmp_rsp_t rsp
);
  // One equality and one unsigned less-or-equal compare.
  always_comb begin
    rsp.eq = (req.a == req.b);
    rsp.le = (req.a <= req.b);
  end
endmodule

[src/counting_semaphore_table.sv]
// Semaphore table top level: command sequencer, tables and result port.
// A command is taken when start is high and busy is low; the result shows on
// status, result_id, action and wake_conn for one cycle with done high. The
// sequencer scans one table row per cycle through a shared compare unit and
// registered-read RAMs. Get scans for a key match and then, when creating, for
// a free row; close needs no scan, and operate may scan the sleeper rows.
// The receiver cannot stall the result. No clearing pass is needed.
`timescale 1ns / 1ps
`include "counting_semaphore_table_assert.svh"
module counting_semaphore_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] key,
  input  logic        create_flag,
  input  logic        exclusive_flag,
  input  logic [7:0]  sem_id,
  input  logic [7:0]  conn_id,
  input  logic signed [15:0] sem_op,
  input  logic        nowait_flag,
  input  logic        undo_flag,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  result_id,
  output logic [1:0]  action,
  output logic [7:0]  wake_conn
);
  localparam int SIW = cst_pkg::SemIdxW;
  localparam int LIW = cst_pkg::SlpIdxW;

  cst_pkg::state_t state;

  // Latched command.
  logic [31:0] c_key;
  logic        c_create, c_excl, c_nowait;
  logic [SIW-1:0] c_id;
  logic [7:0]  c_conn;
  logic [15:0] c_mag;
  logic        c_pos, c_neg;

  // Flip-flop control tables.
  logic [cst_pkg::SemCount-1:0]     used;
  logic [15:0]                      refs [cst_pkg::SemCount];
  logic [cst_pkg::SleeperCount-1:0] svalid;

  // Scan counters and results.
  logic [cst_pkg::SemCntW-1:0] sidx;
  logic [cst_pkg::SlpCntW-1:0] lidx;
  logic [15:0] value;
  logic        phase;   // get: 0 key scan, 1 free scan

  // RAM ports.
  logic           key_we, val_we, slp_we;
  logic [SIW-1:0] key_wa, key_ra, val_wa, val_ra;
  logic [31:0]    key_wd, key_rd;
  logic [15:0]    val_wd, val_rd;
  logic [LIW-1:0] slp_wa, slp_ra;
  logic [31:0]    slp_wd, slp_rd;   // {conn, entry, need}

  cst_ram #(.Width(32), .Depth(cst_pkg::SemCount)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
  cst_ram #(.Width(16), .Depth(cst_pkg::SemCount)) u_val (
    .clk, .we(val_we), .waddr(val_wa), .wdata(val_wd), .raddr(val_ra), .rdata(val_rd));
  cst_ram #(.Width(32), .Depth(cst_pkg::SleeperCount)) u_slp (
    .clk, .we(slp_we), .waddr(slp_wa), .wdata(slp_wd), .raddr(slp_ra), .rdata(slp_rd));

  cst_pkg::cmp_req_t creq;
  cst_pkg::cmp_rsp_t crsp;
  cst_cmp u_cmp (.req(creq), .rsp(crsp));

  // Row addresses: the row read this cycle is the one at sidx or lidx.
  // While idle the key RAM reads row 0 so that a get scan starts there.
  logic [SIW-1:0] srow;
  logic [LIW-1:0] lrow;
  logic [SIW-1:0] prow;   // row whose data is on key_rd now
  logic [LIW-1:0] plrow;
  assign srow = sidx[SIW-1:0];
  assign lrow = lidx[LIW-1:0];
  assign key_ra = (state == cst_pkg::S_IDLE) ? '0 : srow;
  assign val_ra = (state == cst_pkg::S_IDLE) ? sem_id[SIW-1:0] : c_id;
  assign slp_ra = lrow;

  // Shared compare: key match during get, need fit during sleeper scan.
  always_comb begin
    if (state == cst_pkg::S_GETSC) begin
      creq.a = key_rd;
      creq.b = c_key;
    end else begin
      creq.a = {16'd0, slp_rd[15:0]};
      creq.b = {16'd0, value};
    end
  end

  logic        hit_valid;
  logic [SIW-1:0] slp_ent;
  assign slp_ent = slp_rd[16 +: SIW];
  assign hit_valid = svalid[plrow] && (slp_rd[23:16] == 8'(c_id)) && crsp.le;

  logic [16:0] sum;
  assign sum = {1'b0, val_rd} + {1'b0, c_mag};

  // Lowest free sleeper slot, used when the caller blocks.
  logic           free_any;
  logic [LIW-1:0] free_slot;
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = cst_pkg::SleeperCount - 1; i >= 0; i--) begin
      if (!svalid[i]) begin
        free_any  = 1'b1;
        free_slot = LIW'(i);
      end
    end
  end

  assign busy = (state != cst_pkg::S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    key_we <= 1'b0;
    val_we <= 1'b0;
    slp_we <= 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state  <= cst_pkg::S_IDLE;
      used   <= '0;
      svalid <= '0;
      for (int i = 0; i < cst_pkg::SemCount; i++) refs[i] <= '0;
    end else begin
      unique case (state)
        cst_pkg::S_IDLE: begin
          if (start) begin
            c_key    <= key;
            c_create <= create_flag;
            c_excl   <= exclusive_flag;
            c_id     <= sem_id[SIW-1:0];
            c_conn   <= conn_id;
            c_nowait <= nowait_flag;
            c_pos    <= (sem_op > 0);
            c_neg    <= (sem_op < 0);
            c_mag    <= (sem_op < 0) ? 16'(-sem_op) : 16'(sem_op);
            status    <= cst_pkg::StOk;
            result_id <= '0;
            action    <= cst_pkg::ActDone;
            wake_conn <= '0;
            sidx  <= '0;
            lidx  <= '0;
            phase <= 1'b0;
            state <= cst_pkg::S_DONE;
            if (cmd == cst_pkg::CmdGet) begin
              if (key == 32'd0) status <= cst_pkg::StNotSup;
              else if (exclusive_flag && !create_flag) status <= cst_pkg::StInval;
              else begin
                sidx  <= cst_pkg::SemCntW'(1);
                prow  <= '0;
                state <= cst_pkg::S_GETSC;
              end
            end else if (cmd == cst_pkg::CmdClose) begin
              if (sem_id >= 8'(cst_pkg::SemCount) || !used[sem_id[SIW-1:0]]) begin
                status <= cst_pkg::StInval;
              end else begin
                if (refs[sem_id[SIW-1:0]] <= 16'd1) used[sem_id[SIW-1:0]] <= 1'b0;
                if (refs[sem_id[SIW-1:0]] != 16'd0)
                  refs[sem_id[SIW-1:0]] <= refs[sem_id[SIW-1:0]] - 16'd1;
              end
            end else if (cmd == cst_pkg::CmdOperate) begin
              if (sem_id >= 8'(cst_pkg::SemCount) || !used[sem_id[SIW-1:0]])
                status <= cst_pkg::StInval;
              else if (undo_flag) status <= cst_pkg::StNotSup;
              else state <= cst_pkg::S_ENTRD;
            end else begin
              status <= cst_pkg::StInval;
            end
          end
        end

        // One entry per cycle: key match first, then lowest free entry.
        cst_pkg::S_GETSC: begin
          prow <= srow;
          sidx <= sidx + cst_pkg::SemCntW'(1);
          if (!phase && used[prow] && crsp.eq) begin
            state <= cst_pkg::S_DONE;
            if (c_create && c_excl) status <= cst_pkg::StExist;
            else begin
              result_id <= 8'(prow);
              if (refs[prow] != cst_pkg::Max16) refs[prow] <= refs[prow] + 16'd1;
            end
          end else if (phase && !used[prow]) begin
            state     <= cst_pkg::S_DONE;
            result_id <= 8'(prow);
            used[prow] <= 1'b1;
            refs[prow] <= 16'd1;
            key_we <= 1'b1; key_wa <= prow; key_wd <= c_key;
            val_we <= 1'b1; val_wa <= prow; val_wd <= '0;
          end else if (prow == SIW'(cst_pkg::SemCount - 1)) begin
            if (phase) begin
              status <= cst_pkg::StNoSpc;
              state  <= cst_pkg::S_DONE;
            end else if (!c_create) begin
              status <= cst_pkg::StNoEnt;
              state  <= cst_pkg::S_DONE;
            end else begin
              phase <= 1'b1;
              sidx  <= cst_pkg::SemCntW'(1);
              prow  <= '0;
            end
          end
        end

        // Entry value is on val_rd: do the arithmetic of the operation.
        cst_pkg::S_ENTRD: begin
          state <= cst_pkg::S_DONE;
          if (c_pos) begin
            value <= sum[16] ? cst_pkg::Max16 : sum[15:0];
            lidx  <= cst_pkg::SlpCntW'(1);
            plrow <= '0;
            state <= cst_pkg::S_SLPSC;
          end else if ((c_neg && val_rd < c_mag) || (!c_neg && val_rd != 16'd0)) begin
            if (!c_nowait) begin
              action <= cst_pkg::ActBlock;
              if (free_any) begin
                svalid[free_slot] <= 1'b1;
                slp_we <= 1'b1;
                slp_wa <= free_slot;
                slp_wd <= {c_conn, 8'(c_id), c_neg ? c_mag : 16'd0};
              end
            end
          end else if (c_neg) begin
            val_we <= 1'b1; val_wa <= c_id; val_wd <= val_rd - c_mag;
          end
        end

        // One sleeper per cycle: wake the lowest one that fits.
        cst_pkg::S_SLPSC: begin
          plrow <= lrow;
          lidx  <= lidx + cst_pkg::SlpCntW'(1);
          if (hit_valid) begin
            svalid[plrow] <= 1'b0;
            action    <= cst_pkg::ActWake;
            wake_conn <= slp_rd[31:24];
            val_we <= 1'b1; val_wa <= c_id; val_wd <= value - slp_rd[15:0];
            state  <= cst_pkg::S_DONE;
          end else if (plrow == LIW'(cst_pkg::SleeperCount - 1)) begin
            val_we <= 1'b1; val_wa <= c_id; val_wd <= value;
            state  <= cst_pkg::S_DONE;
          end
        end

        cst_pkg::S_SLPIN: state <= cst_pkg::S_DONE;

        cst_pkg::S_DONE: begin
          done  <= 1'b1;
          state <= cst_pkg::S_IDLE;
        end

        default: state <= cst_pkg::S_IDLE;
      endcase
    end
  end

  `CST_ASSERT_NEXT(a_done_idle, clk, rst, done, !done, "done lasted more than one cycle")
  `CST_ASSERT_IMP(a_wake_ok, clk, rst, done && action == cst_pkg::ActWake, status == cst_pkg::StOk, "wake with bad status")
  `CST_ASSERT_IMP(a_busy_done, clk, rst, state == cst_pkg::S_DONE, busy, "not busy while finishing")
  `CST_ASSERT_IMP(a_slp_entry, clk, rst, state == cst_pkg::S_SLPSC && hit_valid, slp_ent == c_id, "woke a sleeper of another entry")
endmodule

[tb/sv/counting_semaphore_table_tb.sv]
// Self-checking testbench of the semaphore table with a built-in predictor.
`timescale 1ns / 1ps
module counting_semaphore_table_tb;
  typedef struct {
    logic [1:0]         cmd;
    logic [31:0]        key;
    logic               create;
    logic               excl;
    logic [7:0]         sem_id;
    logic [7:0]         conn_id;
    logic signed [15:0] op;
    logic               nowait;
    logic               undo;
  } sem_cmd_t;

  typedef struct {
    logic [2:0] status;
    logic [7:0] result_id;
    logic [1:0] action;
    logic [7:0] wake_conn;
  } sem_res_t;

  localparam int IdleLimit = 3000;
  // Command code that the block does not know.
  localparam logic [1:0] CmdBad = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd = '0;
  logic [31:0] key = '0;
  logic create_flag = 1'b0;
  logic exclusive_flag = 1'b0;
  logic [7:0] sem_id = '0;
  logic [7:0] conn_id = '0;
  logic signed [15:0] sem_op = '0;
  logic nowait_flag = 1'b0;
  logic undo_flag = 1'b0;
  logic done;
  logic [2:0] status;
  logic [7:0] result_id;
  logic [1:0] action;
  logic [7:0] wake_conn;

  // Shadow copy of the semaphore and sleeper tables.
  bit          ent_used[cst_pkg::SemCount];
  logic [31:0] ent_key[cst_pkg::SemCount];
  int          ent_refs[cst_pkg::SemCount];
  int          ent_value[cst_pkg::SemCount];
  bit          slp_valid[cst_pkg::SleeperCount];
  logic [7:0]  slp_conn[cst_pkg::SleeperCount];
  int          slp_entry[cst_pkg::SleeperCount];
  int          slp_need[cst_pkg::SleeperCount];

  sem_res_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  logic [31:0] key_pool[24];

  counting_semaphore_table uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .key(key),
    .create_flag(create_flag), .exclusive_flag(exclusive_flag), .sem_id(sem_id),
    .conn_id(conn_id), .sem_op(sem_op), .nowait_flag(nowait_flag),
    .undo_flag(undo_flag), .done(done), .status(status), .result_id(result_id),
    .action(action), .wake_conn(wake_conn)
  );

  always #10 clk = ~clk;

  // Store a blocked caller in the lowest free sleeper slot, if there is one.
  function automatic void park_sleeper(logic [7:0] conn, int ent, int need);
    bit placed;
    placed = 1'b0;
    for (int i = 0; i < cst_pkg::SleeperCount; i++) begin
      if (!placed && !slp_valid[i]) begin
        placed = 1'b1;
        slp_valid[i] = 1'b1;
        slp_conn[i] = conn;
        slp_entry[i] = ent;
        slp_need[i] = need;
      end
    end
  endfunction

  // Apply one command to the shadow tables and return its result.
  function automatic sem_res_t apply_sem_cmd(sem_cmd_t c);
    sem_res_t r;
    bit hit;
    int id;
    int v;
    int need;
    r = '{cst_pkg::StOk, 8'd0, cst_pkg::ActDone, 8'd0};
    hit = 1'b0;
    id = c.sem_id;
    case (c.cmd)
      cst_pkg::CmdGet: begin
        if (c.key == 32'd0) begin
          r.status = cst_pkg::StNotSup;
        end else if (c.excl && !c.create) begin
          r.status = cst_pkg::StInval;
        end else begin
          for (int i = 0; i < cst_pkg::SemCount; i++) begin
            if (!hit && ent_used[i] && ent_key[i] == c.key) begin
              hit = 1'b1;
              if (c.create && c.excl) begin
                r.status = cst_pkg::StExist;
              end else begin
                if (ent_refs[i] < 65535) ent_refs[i]++;
                r.result_id = i[7:0];
              end
            end
          end
          if (!hit) begin
            if (!c.create) begin
              r.status = cst_pkg::StNoEnt;
            end else begin
              r.status = cst_pkg::StNoSpc;
              for (int i = 0; i < cst_pkg::SemCount; i++) begin
                if (!hit && !ent_used[i]) begin
                  hit = 1'b1;
                  ent_used[i] = 1'b1;
                  ent_key[i] = c.key;
                  ent_value[i] = 0;
                  ent_refs[i] = 1;
                  r.status = cst_pkg::StOk;
                  r.result_id = i[7:0];
                end
              end
            end
          end
        end
      end
      cst_pkg::CmdClose: begin
        if (id >= cst_pkg::SemCount || !ent_used[id]) begin
          r.status = cst_pkg::StInval;
        end else begin
          if (ent_refs[id] > 0) ent_refs[id]--;
          if (ent_refs[id] == 0) ent_used[id] = 1'b0;
        end
      end
      cst_pkg::CmdOperate: begin
        if (id >= cst_pkg::SemCount || !ent_used[id]) begin
          r.status = cst_pkg::StInval;
        end else if (c.undo) begin
          r.status = cst_pkg::StNotSup;
        end else if (c.op > 0) begin
          v = ent_value[id] + int'(c.op);
          ent_value[id] = (v > 65535) ? 65535 : v;
          // Wake the lowest sleeper on this entry whose need now fits.
          for (int i = 0; i < cst_pkg::SleeperCount; i++) begin
            if (!hit && slp_valid[i] && slp_entry[i] == id &&
                slp_need[i] <= ent_value[id]) begin
              hit = 1'b1;
              slp_valid[i] = 1'b0;
              ent_value[id] -= slp_need[i];
              r.action = cst_pkg::ActWake;
              r.wake_conn = slp_conn[i];
            end
          end
        end else if (c.op < 0) begin
          need = -int'(c.op);
          if (ent_value[id] < need) begin
            if (!c.nowait) begin
              park_sleeper(c.conn_id, id, need);
              r.action = cst_pkg::ActBlock;
            end
          end else begin
            ent_value[id] -= need;
          end
        end else if (ent_value[id] > 0 && !c.nowait) begin
          park_sleeper(c.conn_id, id, 0);
          r.action = cst_pkg::ActBlock;
        end
      end
      default: r.status = cst_pkg::StInval;
    endcase
    return r;
  endfunction

  // Send one item after a random gap; entered and left just after a falling edge.
  task automatic send_item(sem_cmd_t c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = c.cmd;
    key = c.key;
    create_flag = c.create;
    exclusive_flag = c.excl;
    sem_id = c.sem_id;
    conn_id = c.conn_id;
    sem_op = c.op;
    nowait_flag = c.nowait;
    undo_flag = c.undo;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_sem_cmd(c));
    @(negedge clk);
  endtask

  function automatic sem_cmd_t make_cmd(logic [1:0] cm, logic [31:0] k, bit cr, bit ex,
                                        logic [7:0] id, logic [7:0] conn, int op,
                                        bit nw, bit ud);
    sem_cmd_t c;
    c = '{cm, k, cr, ex, id, conn, op[15:0], nw, ud};
    return c;
  endfunction

  // Compare every result with the oldest expectation.
  always @(posedge clk) begin
    sem_res_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0d/%0d/%0d/%0d", $time,
                 status, result_id, action, wake_conn);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
        if (result_id !== e.result_id) begin
          $display("%0t: result_id expected %0d actual %0d", $time, e.result_id, result_id);
          errors++;
        end
        if (action !== e.action) begin
          $display("%0t: action expected %0d actual %0d", $time, e.action, action);
          errors++;
        end
        if (wake_conn !== e.wake_conn) begin
          $display("%0t: wake_conn expected %0d actual %0d", $time, e.wake_conn, wake_conn);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item accepted and no result.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Key checks in order, lookup, creation, exclusive and reference counting.
  task automatic test_get_checks();
    send_item(make_cmd(cst_pkg::CmdGet, 32'd0, 1, 1, 0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdGet, 32'hFFFFFFFF, 0, 1, 0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdGet, 32'd1, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdGet, 32'd1, 1, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdGet, 32'd1, 1, 1, 0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdGet, 32'd1, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdGet, 32'hFFFFFFFF, 1, 1, 0, 0, 0, 0, 0));
  endtask

  // Bad index, undo, block, wakeups, saturation, the unknown command and closes.
  task automatic test_operate();
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd255, 0, 1, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 0, 1, 0, 1));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 8'd7, -5, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 0, 0, 1, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 0, 32767, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 0, 32767, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 0, 32767, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 0, -32768, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 8'd0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 8'hFF, 1, 0, 0));
    send_item(make_cmd(cst_pkg::CmdOperate, 0, 0, 0, 8'd0, 0, -32768, 1, 0));
    send_item(make_cmd(CmdBad, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdClose, 0, 0, 0, 8'd0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdClose, 0, 0, 0, 8'd0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdClose, 0, 0, 0, 8'd0, 0, 0, 0, 0));
    send_item(make_cmd(cst_pkg::CmdClose, 0, 0, 0, 8'd16, 0, 0, 0, 0));
  endtask

  // Random commands on a pool of keys larger than the table, ids mostly in use.
  task automatic test_random(int count);
    sem_cmd_t c;
    int used_ids[$];
    int sel;
    int op;
    for (int n = 0; n < count; n++) begin
      used_ids.delete();
      for (int i = 0; i < cst_pkg::SemCount; i++) if (ent_used[i]) used_ids.push_back(i);
      c.key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
      if ($urandom_range(0, 29) == 0) c.key = 32'd0;
      c.create = ($urandom_range(0, 3) != 0);
      c.excl = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0) c.sem_id = 8'($urandom_range(0, 255));
      else if (sel == 1 || used_ids.size() == 0)
        c.sem_id = 8'($urandom_range(0, cst_pkg::SemCount - 1));
      else c.sem_id = 8'(used_ids[$urandom_range(0, used_ids.size() - 1)]);
      c.conn_id = 8'($urandom_range(0, 255));
      sel = $urandom_range(0, 11);
      if (sel == 0) op = -32768;
      else if (sel == 1) op = 32767;
      else if (sel == 2) op = $urandom_range(0, 65535) - 32768;
      else op = $urandom_range(0, 10) - 5;
      c.op = op[15:0];
      c.nowait = ($urandom_range(0, 3) == 0);
      c.undo = ($urandom_range(0, 15) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 6) c.cmd = cst_pkg::CmdGet;
      else if (sel < 9) c.cmd = cst_pkg::CmdClose;
      else if (sel < 19) c.cmd = cst_pkg::CmdOperate;
      else c.cmd = CmdBad;
      send_item(c);
    end
  endtask

  initial begin
    key_pool[0] = 32'd1;
    key_pool[1] = 32'hFFFFFFFF;
    for (int i = 2; i < 24; i++) key_pool[i] = $urandom | 32'd1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_get_checks();
    test_operate();
    test_random(650);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
